// File: rtl/enbt_pkg.sv
// ----------------------------------------------------------------------------
// enbt_pkg
// Shared types and constants of the expiring neighbor block table.
// ----------------------------------------------------------------------------
package enbt_pkg;

	localparam int CAPACITY  = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int RES_LIMIT = 32;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_DEL    = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MAX_ENT = 2'd2;
	localparam logic [1:0] REG_MAX_EXP = 2'd3;

	localparam logic ACT_INSTALL   = 1'b0;
	localparam logic ACT_UNINSTALL = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] vrf_id;
		logic        is_v6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
	} in_t;

	typedef struct packed {
		logic        action;
		logic [31:0] out_vrf_id;
		logic        out_is_v6;
		logic [63:0] out_addr_hi;
		logic [63:0] out_addr_lo;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [31:0] vrf;
		logic        v6;
		logic [63:0] hi;
		logic [63:0] lo;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] expiry;
		logic [31:0] age;
	} ent_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic scan_start;
		logic entry_write;
		logic del_match;
		logic del_best;
		logic emit;
		logic emit_pend;
		logic action;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic             enable;
		logic             aging;
		logic [CNT_W-1:0] max_exp;
		logic             add_limit;
		logic             scan_done;
		logic             match_found;
		logic             free_found;
		logic             best_found;
		logic             best_expired;
	} sts_t;

endpackage

// File: rtl/enbt_datapath.sv
// ----------------------------------------------------------------------------
// enbt_datapath
// Entry memory, valid bits, configuration, table scan and result register.
// ----------------------------------------------------------------------------
module enbt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  enbt_pkg::in_t       in_item,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  enbt_pkg::cmd_t      cmd,
	output enbt_pkg::sts_t      sts,
	output logic                result_valid,
	output enbt_pkg::out_t      result
);

	logic                          enable_q;
	logic [15:0]                   timeout_q;
	logic [enbt_pkg::CNT_W-1:0]    max_ent_q;
	logic [enbt_pkg::CNT_W-1:0]    max_exp_q;
	logic [31:0]                   now_q;
	logic [31:0]                   seq_q;
	logic [enbt_pkg::CNT_W-1:0]    count_q;
	logic [enbt_pkg::CAPACITY-1:0] valid_q;

	enbt_pkg::ent_t                mem [enbt_pkg::CAPACITY];
	enbt_pkg::key_t                key_q;
	enbt_pkg::key_t                pend_q;
	enbt_pkg::key_t                in_key;

	logic [enbt_pkg::CNT_W-1:0]    scan_cnt_q;
	logic                          scan_run_q;
	enbt_pkg::ent_t                rd_s1;
	logic                          rd_vld_s1;
	logic                          rd_live_s1;
	logic [enbt_pkg::IDX_W-1:0]    rd_idx_s1;

	logic                          match_q;
	logic                          free_q;
	logic                          best_q;
	logic [enbt_pkg::IDX_W-1:0]    match_idx_q;
	logic [enbt_pkg::IDX_W-1:0]    free_idx_q;
	logic [enbt_pkg::IDX_W-1:0]    best_idx_q;
	logic [31:0]                   best_exp_q;
	logic [31:0]                   best_age_q;
	enbt_pkg::key_t                best_key_q;

	logic                          scan_done;
	logic                          better;
	logic [31:0]                   new_expiry;

	// An IPv4 key keeps only the low 32 address bits.
	always_comb begin
		in_key.vrf = in_item.vrf_id;
		in_key.v6  = in_item.is_v6;
		in_key.hi  = in_item.is_v6 ? in_item.addr_hi : 64'd0;
		in_key.lo  = in_item.is_v6 ? in_item.addr_lo : {32'd0, in_item.addr_lo[31:0]};
	end

	assign scan_done  = scan_run_q && (scan_cnt_q == enbt_pkg::CNT_W'(enbt_pkg::CAPACITY))
		&& !rd_vld_s1;
	assign better     = !best_q || (rd_s1.expiry < best_exp_q) ||
		((rd_s1.expiry == best_exp_q) && (rd_s1.age < best_age_q));
	assign new_expiry = (timeout_q != 16'd0) ? (now_q + {16'd0, timeout_q}) : 32'd0;

	always_comb begin
		sts.enable       = enable_q;
		sts.aging        = (timeout_q != 16'd0);
		sts.max_exp      = max_exp_q;
		sts.add_limit    = (max_ent_q != '0) && (count_q >= max_ent_q);
		sts.scan_done    = scan_done;
		sts.match_found  = match_q;
		sts.free_found   = free_q;
		sts.best_found   = best_q;
		sts.best_expired = (best_exp_q <= now_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			timeout_q <= 16'd300;
			max_ent_q <= '0;
			max_exp_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				enbt_pkg::REG_ENABLE:  enable_q  <= cfg_data[0];
				enbt_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				enbt_pkg::REG_MAX_ENT: max_ent_q <= cfg_data[enbt_pkg::CNT_W-1:0];
				enbt_pkg::REG_MAX_EXP: max_exp_q <= cfg_data[enbt_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			seq_q   <= '0;
			count_q <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.tick) begin
				now_q <= now_q + 32'd1;
			end
			if (cmd.entry_write) begin
				valid_q[free_idx_q] <= 1'b1;
				seq_q               <= seq_q + 32'd1;
				count_q             <= count_q + 1'b1;
			end
			if (cmd.del_match) begin
				valid_q[match_idx_q] <= 1'b0;
				count_q              <= count_q - 1'b1;
			end
			if (cmd.del_best) begin
				valid_q[best_idx_q] <= 1'b0;
				count_q             <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.entry_write) begin
			mem[free_idx_q] <= '{key: key_q, expiry: new_expiry, age: seq_q};
		end
		if (scan_run_q && (scan_cnt_q < enbt_pkg::CNT_W'(enbt_pkg::CAPACITY))) begin
			rd_s1 <= mem[scan_cnt_q[enbt_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
		end
		if (cmd.del_best) begin
			pend_q <= best_key_q;
		end
	end

	// Scan: one entry read per cycle, compared in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q <= 1'b0;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			best_q     <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_run_q <= 1'b1;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			best_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_run_q && (scan_cnt_q < enbt_pkg::CNT_W'(enbt_pkg::CAPACITY));
			if (scan_run_q && (scan_cnt_q < enbt_pkg::CNT_W'(enbt_pkg::CAPACITY))) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (scan_done) begin
				scan_run_q <= 1'b0;
			end
			if (rd_vld_s1) begin
				if (rd_live_s1) begin
					if (!match_q && (rd_s1.key == key_q)) begin
						match_q <= 1'b1;
					end
					if (better) begin
						best_q <= 1'b1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_run_q && (scan_cnt_q < enbt_pkg::CNT_W'(enbt_pkg::CAPACITY))) begin
			rd_idx_s1  <= scan_cnt_q[enbt_pkg::IDX_W-1:0];
			rd_live_s1 <= valid_q[scan_cnt_q[enbt_pkg::IDX_W-1:0]];
		end
		if (rd_vld_s1 && !cmd.scan_start) begin
			if (rd_live_s1) begin
				if (!match_q && (rd_s1.key == key_q)) begin
					match_idx_q <= rd_idx_s1;
				end
				if (better) begin
					best_idx_q <= rd_idx_s1;
					best_exp_q <= rd_s1.expiry;
					best_age_q <= rd_s1.age;
					best_key_q <= rd_s1.key;
				end
			end else if (!free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.action      <= cmd.action;
			result.out_vrf_id  <= cmd.emit_pend ? pend_q.vrf : key_q.vrf;
			result.out_is_v6   <= cmd.emit_pend ? pend_q.v6  : key_q.v6;
			result.out_addr_hi <= cmd.emit_pend ? pend_q.hi  : key_q.hi;
			result.out_addr_lo <= cmd.emit_pend ? pend_q.lo  : key_q.lo;
			result.last        <= cmd.last;
		end
	end

endmodule

// File: rtl/enbt_ctrl.sv
// ----------------------------------------------------------------------------
// enbt_ctrl
// Sequencer for add, delete and tick items over the table scan.
// ----------------------------------------------------------------------------
module enbt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      kind,
	input  enbt_pkg::sts_t  sts,
	output logic            busy,
	output enbt_pkg::cmd_t  cmd
);

	enbt_pkg::state_t              state_q, state_d;
	logic [1:0]                    kind_q;
	logic [enbt_pkg::CNT_W-1:0]    n_q, n_d;
	logic                          pend_q, pend_d;
	logic                          cand;
	logic                          more;
	logic [enbt_pkg::CNT_W-1:0]    n_inc;

	assign busy  = (state_q != enbt_pkg::ST_IDLE);
	assign n_inc = n_q + 1'b1;
	// A flush ignores expiry and the per-tick expiration limit.
	assign cand  = sts.best_found && (!sts.enable || sts.best_expired);
	assign more  = (n_inc < enbt_pkg::CNT_W'(enbt_pkg::RES_LIMIT)) &&
		(!sts.enable || (sts.max_exp == '0) || (n_inc < sts.max_exp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= enbt_pkg::ST_IDLE;
			kind_q  <= enbt_pkg::KIND_ADD;
			n_q     <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			pend_q  <= pend_d;
			if (start && !busy) begin
				kind_q <= kind;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		n_d     = n_q;
		pend_d  = pend_q;
		cmd     = '0;
		unique case (state_q)
			enbt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (kind)
						enbt_pkg::KIND_ADD: begin
							if (sts.enable && !sts.add_limit) begin
								cmd.scan_start = 1'b1;
								state_d        = enbt_pkg::ST_SCAN;
							end
						end
						enbt_pkg::KIND_DEL: begin
							if (sts.enable) begin
								cmd.scan_start = 1'b1;
								state_d        = enbt_pkg::ST_SCAN;
							end
						end
						enbt_pkg::KIND_TICK: begin
							cmd.tick = 1'b1;
							n_d      = '0;
							pend_d   = 1'b0;
							if (!sts.enable || sts.aging) begin
								cmd.scan_start = 1'b1;
								state_d        = enbt_pkg::ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			enbt_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = enbt_pkg::ST_DECIDE;
				end
			end
			enbt_pkg::ST_DECIDE: begin
				state_d = enbt_pkg::ST_IDLE;
				unique case (kind_q)
					enbt_pkg::KIND_ADD: begin
						if (!sts.match_found && sts.free_found) begin
							cmd.entry_write = 1'b1;
							cmd.emit        = 1'b1;
							cmd.action      = enbt_pkg::ACT_INSTALL;
							cmd.last        = 1'b1;
						end
					end
					enbt_pkg::KIND_DEL: begin
						if (sts.match_found) begin
							cmd.del_match = 1'b1;
							cmd.emit      = 1'b1;
							cmd.action    = enbt_pkg::ACT_UNINSTALL;
							cmd.last      = 1'b1;
						end
					end
					default: begin
						// The previous removal is sent only once it is known
						// whether another one follows it.
						cmd.emit      = pend_q;
						cmd.emit_pend = 1'b1;
						cmd.action    = enbt_pkg::ACT_UNINSTALL;
						if (cand) begin
							cmd.del_best   = 1'b1;
							pend_d         = 1'b1;
							n_d            = n_inc;
							if (more) begin
								cmd.scan_start = 1'b1;
								state_d        = enbt_pkg::ST_SCAN;
							end else begin
								state_d = enbt_pkg::ST_FINAL;
							end
						end else begin
							cmd.last = 1'b1;
						end
					end
				endcase
			end
			enbt_pkg::ST_FINAL: begin
				cmd.emit      = 1'b1;
				cmd.emit_pend = 1'b1;
				cmd.action    = enbt_pkg::ACT_UNINSTALL;
				cmd.last      = 1'b1;
				state_d       = enbt_pkg::ST_IDLE;
			end
			default: state_d = enbt_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: rtl/expiring_neighbor_block_table.sv
// ----------------------------------------------------------------------------
// expiring_neighbor_block_table
// Table of blocked neighbor keys with expiry, add/delete/tick commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy falls in the cycle
// that the final result of that item appears. Results appear for one cycle each
// with result_valid high, the final one with last set; there is no stall.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data; the user must make them while the block is idle, the block does not check.
// An accepted add or delete, and a tick with aging on or the block disabled,
// walks the 32-entry memory one entry per cycle; a refused add or delete does
// not scan. A tick rescans after each removed entry, up to 32 removals per tick.
// Reset clears the valid bits, the entry count, the time and the insertion
// sequence, and loads the register defaults (timeout 300 ticks, the rest zero).
// ----------------------------------------------------------------------------
module expiring_neighbor_block_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  enbt_pkg::in_t   in_item,
	output logic            result_valid,
	output enbt_pkg::out_t  result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	enbt_pkg::cmd_t cmd;
	enbt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	enbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (in_item.kind),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	enbt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_item      (in_item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
